// File: src/deq_pkg.sv
// Shared types and codes for the double-ended queue.
package deq_pkg;

   typedef logic [2:0] deq_mode_type;
   typedef logic [1:0] deq_status_type;

   // command codes carried in req_mode
   localparam deq_mode_type MODE_PUSH_FRONT = 3'd0;
   localparam deq_mode_type MODE_PUSH_BACK  = 3'd1;
   localparam deq_mode_type MODE_POP_FRONT  = 3'd2;
   localparam deq_mode_type MODE_POP_BACK   = 3'd3;
   localparam deq_mode_type MODE_PEEK_FRONT = 3'd4;
   localparam deq_mode_type MODE_PEEK_BACK  = 3'd5;
   localparam deq_mode_type MODE_EMPTY      = 3'd6;
   localparam deq_mode_type MODE_SIZE       = 3'd7;

   // result status codes
   localparam deq_status_type ST_OK    = 2'd0;
   localparam deq_status_type ST_EMPTY = 2'd1;
   localparam deq_status_type ST_FULL  = 2'd2;

   localparam logic [31:0] WORD_NONE = 32'hFFFF_FFFF;

   // controller to datapath
   typedef struct packed {
      logic         take;          // item accepted this cycle
      deq_mode_type mode;          // its command code
      logic         capture_read;  // load the RAM read word into the result
   } deq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
   } deq_stat_type;

endpackage

// File: src/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/deq_ctrl.sv
// Handshake controller for the double-ended queue.
module deq_ctrl import deq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  deq_mode_type req_mode,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  deq_stat_type stat,
   output deq_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       take;
   logic       needs_read;
   logic       next_state_busy;

   // free to take an item when idle or when the waiting result leaves now
   assign req_stall = !((state_ff == S_IDLE) || ((state_ff == S_RESP) && !rsp_stall));
   assign take      = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_RESP);

   assign needs_read = (req_mode inside {MODE_POP_FRONT, MODE_POP_BACK,
                                         MODE_PEEK_FRONT, MODE_PEEK_BACK}) && !stat.empty;

   always_comb begin
      next_state_busy = 1'b0;
      state_in        = state_ff;
      case (state_ff)
         S_IDLE: begin
            next_state_busy = take;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               next_state_busy = take;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (next_state_busy) begin
         state_in = needs_read ? S_READ : S_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.take         = take;
   assign cmd.mode         = req_mode;
   assign cmd.capture_read = (state_ff == S_READ);

   a_read_then_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_RESP))
      else $error("read state not followed by result");

   a_take_read: assert property (@(posedge clock) disable iff (reset)
      (take && needs_read) |=> (state_ff == S_READ))
      else $error("memory read item did not wait for read data");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !take) |=> (state_ff == S_IDLE))
      else $error("controller busy after last result left");

endmodule

// File: src/deq_dpath.sv
// Pointer, occupancy and result datapath for the double-ended queue.
module deq_dpath import deq_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [31:0]    req_value,
   input  deq_cmd_type    cmd,
   output deq_stat_type   stat,
   output deq_status_type rsp_status,
   output logic [31:0]    rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  occ_ff, occ_in;
   deq_status_type status_ff, status_in;
   logic [31:0]    data_ff, data_in;

   logic [SW-1:0]  back_sum, tail_sum;
   logic [AW-1:0]  back_pos, tail_pos, head_dec, head_inc;
   logic           empty, full;
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [31:0]    rd_data;

   assign empty = (occ_ff == '0);
   assign full  = (occ_ff == FULL_CNT);
   assign stat.empty = empty;

   // slot past the back, and the back entry itself
   assign back_sum = SW'(head_ff) + SW'(occ_ff);
   assign tail_sum = back_sum - SW'(1);
   assign back_pos = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
   assign tail_pos = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - AW'(1);
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);

   always_comb begin
      head_in   = head_ff;
      occ_in    = occ_ff;
      status_in = status_ff;
      data_in   = data_ff;
      wr_en     = 1'b0;
      wr_addr   = back_pos;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      if (cmd.take) begin
         status_in = ST_OK;
         data_in   = '0;
         case (cmd.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en  = 1'b1;
                  occ_in = occ_ff + CW'(1);
                  if (cmd.mode == MODE_PUSH_FRONT) begin
                     wr_addr = head_dec;
                     head_in = head_dec;
                  end
               end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT, MODE_POP_BACK, MODE_PEEK_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
                  data_in   = WORD_NONE;
               end else begin
                  rd_en = 1'b1;
                  if (cmd.mode inside {MODE_POP_BACK, MODE_PEEK_BACK}) begin
                     rd_addr = tail_pos;
                  end
                  if (cmd.mode inside {MODE_POP_FRONT, MODE_POP_BACK}) begin
                     occ_in = occ_ff - CW'(1);
                  end
                  if (cmd.mode == MODE_POP_FRONT) begin
                     head_in = head_inc;
                  end
               end
            end
            MODE_EMPTY: begin
               data_in = 32'(empty);
            end
            default: begin
               data_in = 32'(occ_ff);
            end
         endcase
      end else if (cmd.capture_read) begin
         data_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   assign rsp_status = status_ff;
   assign rsp_data   = data_ff;

   deq_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_CNT)
      else $error("occupancy beyond depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && !full && (cmd.mode == MODE_PUSH_FRONT || cmd.mode == MODE_PUSH_BACK))
      |=> (occ_ff == $past(occ_ff) + CW'(1)))
      else $error("accepted push did not grow the queue");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && !empty && (cmd.mode == MODE_POP_FRONT || cmd.mode == MODE_POP_BACK))
      |=> (occ_ff == $past(occ_ff) - CW'(1)))
      else $error("pop did not shrink the queue");

endmodule

// File: src/double_ended_queue.sv
// Top level of the double-ended queue: controller, datapath and entry store.
//
// Double-ended queue of signed 32-bit words kept in a circular buffer of
// DEPTH entries (one RAM with a registered read port). Each command item
// gives exactly one result item with a status and a data word. Pushes,
// empty and size queries, and pops or peeks that find the queue empty
// present their result the cycle after the item is taken; a pop or peek
// that returns a stored word waits in the read state for the registered RAM
// read. One item is in flight at a time, but the next item is taken in the
// same cycle as the waiting result leaves, so commands that do not read the
// RAM run at one item per cycle unless the receiver stalls; no item is
// taken during a RAM read. A push onto a full queue is refused with status
// full and leaves the queue as it was. No clearing pass is needed after
// reset: only entries inside the occupied window are ever read.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   // command items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data
);

   deq_cmd_type  cmd;
   deq_stat_type stat;
   logic [31:0]  data_word;

   // sequence items, decide when to wait for the RAM read
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // advance pointers, hold the result item
   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_status),
      .rsp_data   (data_word)
   );

   assign rsp_data = data_word;

endmodule

// File: bench/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue: directed rows, then random bursts.
module tb_double_ended_queue import deq_pkg::*;;

   localparam int QUEUE_DEPTH    = 128;
   localparam int RANDOM_ITEMS   = 1350;   // spread over the three idling phases
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake on either channel
   localparam int PRINT_LIMIT    = 60;     // mismatch lines printed before going quiet
   localparam int OWED_SLOTS     = 16;     // results owed but not yet taken

   // one result item: what the block must hand back for one command
   typedef struct packed {
      deq_status_type status;
      logic [31:0]    data;
   } deq_result_type;

   // one row of the directed stimulus; typed rows carry their answer,
   // the others are checked against the shadow queue
   typedef struct packed {
      deq_mode_type   mode;
      logic [31:0]    value;
      logic           typed;
      deq_status_type status;
      logic [31:0]    data;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 24;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // fresh from reset: nothing stored
      '{MODE_SIZE,       32'h0000_0000, 1'b1, ST_OK,    32'd0},
      '{MODE_EMPTY,      32'h0000_0000, 1'b1, ST_OK,    32'd1},
      '{MODE_POP_FRONT,  32'hFFFF_FFFF, 1'b1, ST_EMPTY, WORD_NONE},
      '{MODE_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY, WORD_NONE},
      '{MODE_PEEK_FRONT, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, WORD_NONE},
      '{MODE_PEEK_BACK,  32'h0000_0000, 1'b1, ST_EMPTY, WORD_NONE},
      // extremes of the word at both ends; front push wraps the head
      '{MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK,    32'd0},
      '{MODE_PUSH_BACK,  32'h8000_0000, 1'b1, ST_OK,    32'd0},
      '{MODE_PEEK_FRONT, 32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_PEEK_BACK,  32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_SIZE,       32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_EMPTY,      32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'd0},
      '{MODE_PUSH_BACK,  32'h0000_0000, 1'b1, ST_OK,    32'd0},
      // drain from both ends down to empty; front pops carry the head back across the wrap
      '{MODE_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_EMPTY,      32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, WORD_NONE},
      // refill after draining back to an empty queue
      '{MODE_PUSH_BACK,  32'h5555_AAAA, 1'b1, ST_OK,    32'd0},
      '{MODE_PEEK_FRONT, 32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,    32'd0},
      '{MODE_SIZE,       32'h0000_0000, 1'b0, ST_OK,    32'd0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_mode = MODE_SIZE;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data;

   // shadow copy of the queue, advanced as each command item is taken
   logic [31:0]        shadow_store [QUEUE_DEPTH];
   logic [6:0]         shadow_head = '0;
   logic [7:0]         shadow_count = '0;

   // results owed by the block, in the order their items were taken
   deq_result_type     owed_results [OWED_SLOTS];
   int                 owed_wr = 0;
   int                 owed_rd = 0;
   int                 error_count = 0;
   int                 result_count = 0;
   int                 quiet_cycles = 0;
   int                 send_idle_pct = 16;
   int                 recv_stall_pct = 80;

   always #4 clock = ~clock;

   double_ended_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data)
   );

   // Advance the shadow queue by one command and return the result it owes.
   function automatic deq_result_type apply_command(deq_mode_type mode, logic [31:0] value);
      deq_result_type res;
      logic [6:0]     back_slot;
      logic [6:0]     tail_slot;
      res.status = ST_OK;
      res.data   = '0;
      back_slot  = shadow_head + shadow_count[6:0];
      tail_slot  = back_slot - 7'd1;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (shadow_count == QUEUE_DEPTH) begin
               res.status = ST_FULL;    // refuse, leave the queue untouched
            end else if (mode == MODE_PUSH_FRONT) begin
               shadow_head = shadow_head - 7'd1;
               shadow_store[shadow_head] = value;
               shadow_count++;
            end else begin
               shadow_store[back_slot] = value;
               shadow_count++;
            end
         end
         MODE_POP_FRONT, MODE_PEEK_FRONT: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
               res.data   = WORD_NONE;
            end else begin
               res.data = shadow_store[shadow_head];
               if (mode == MODE_POP_FRONT) begin
                  shadow_head = shadow_head + 7'd1;
                  shadow_count--;
               end
            end
         end
         MODE_POP_BACK, MODE_PEEK_BACK: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
               res.data   = WORD_NONE;
            end else begin
               res.data = shadow_store[tail_slot];
               if (mode == MODE_POP_BACK) begin
                  shadow_count--;
               end
            end
         end
         MODE_EMPTY: res.data = (shadow_count == 0) ? 32'd1 : 32'd0;
         default:    res.data = {24'd0, shadow_count};
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t ns: result %0d %s is %h, expected %h", $time, result_count, what, seen,
                  wanted);
      end
      error_count++;
   endtask

   // Offer one command item, hold it until taken, then log its expected result.
   task automatic send_command(deq_mode_type mode, logic [31:0] value, logic typed,
                               deq_result_type typed_result);
      deq_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      res = apply_command(mode, value);
      owed_results[owed_wr % OWED_SLOTS] = typed ? typed_result : res;
      owed_wr++;
   endtask

   // Mostly random words, with the extremes thrown in now and then.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // One burst of commands: fill past full, drain past empty, or a random mix.
   task automatic run_burst(output int issued);
      int             kind;
      int             length;
      deq_mode_type   mode;
      deq_result_type unused;
      unused = '0;
      kind   = $urandom_range(9);
      length = (kind < 4) ? QUEUE_DEPTH + $urandom_range(1, 6) : $urandom_range(4, 24);
      for (int i = 0; i < length; i++) begin
         if (kind < 2) begin
            mode = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         end else if (kind < 4) begin
            case ($urandom_range(7))
               0:       mode = $urandom_range(1) ? MODE_PEEK_FRONT : MODE_PEEK_BACK;
               1, 2, 3: mode = MODE_POP_FRONT;
               default: mode = MODE_POP_BACK;
            endcase
         end else begin
            mode = deq_mode_type'($urandom_range(7));
         end
         send_command(mode, pick_word(), 1'b0, unused);
      end
      issued = length;
   endtask

   // Check each result taken, drive the receiver stall and keep the watchdog.
   always @(posedge clock) begin
      deq_result_type wanted;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_wr == owed_rd) begin
               report_mismatch("arrived unasked, data", rsp_data, 32'hx);
            end else begin
               wanted = owed_results[owed_rd % OWED_SLOTS];
               owed_rd++;
               if (rsp_status !== wanted.status) begin
                  report_mismatch("status", {30'd0, rsp_status}, {30'd0, wanted.status});
               end
               if (rsp_data !== wanted.data) begin
                  report_mismatch("data", rsp_data, wanted.data);
               end
            end
            result_count++;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      int             issued;
      int             phase_items;
      deq_result_type typed_result;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows run under the first idling mix
      for (int row = 0; row < DIRECTED_COUNT; row++) begin
         typed_result.status = DIRECTED_ROWS[row].status;
         typed_result.data   = DIRECTED_ROWS[row].data;
         send_command(DIRECTED_ROWS[row].mode, DIRECTED_ROWS[row].value,
                      DIRECTED_ROWS[row].typed, typed_result);
      end

      // quick sender and busy receiver, then the reverse, then flat out
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 16; recv_stall_pct = 80; end
            1:       begin send_idle_pct = 80; recv_stall_pct = 16; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / 3) begin
            run_burst(issued);
            phase_items += issued;
         end
      end

      // drop valid, wait for the last results, then watch for stray ones
      req_valid <= 1'b0;
      while (owed_wr != owed_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
